/* sv/shr_pkg.sv */
package shr_pkg;

	// request function codes
	localparam logic FUNC_ADD   = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	// store selector codes
	localparam logic [1:0] UNIT_KILO   = 2'd0;
	localparam logic [1:0] UNIT_MEGA   = 2'd1;
	localparam logic [1:0] UNIT_GIGA   = 2'd2;
	localparam logic [1:0] UNIT_UNUSED = 2'd3;

	localparam int SIZE_W  = 31;
	localparam int FIELD_W = 10;
	localparam int SUM_W   = 42;
	localparam logic [SUM_W-1:0] SUM_MAX = '1;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_ADD,
		S_QUERY,
		S_DONE
	} state_t;

	// decoded add request
	typedef struct packed {
		logic               bump;
		logic [1:0]         unit;
		logic [FIELD_W-1:0] bin;
	} add_dec_t;

endpackage

/* sv/shr_if.sv */
interface shr_req_if import shr_pkg::*;;
	logic               valid;
	logic               ready;
	logic               func;
	logic [SIZE_W-1:0]  size_bytes;
	logic [1:0]         unit_select;
	logic [FIELD_W-1:0] range_low;
	logic [FIELD_W-1:0] range_high;

	modport source (output valid, func, size_bytes, unit_select, range_low, range_high,
		input ready);
	modport sink (input valid, func, size_bytes, unit_select, range_low, range_high,
		output ready);
endinterface

interface shr_rsp_if import shr_pkg::*;;
	logic             valid;
	logic             ready;
	logic [SUM_W-1:0] range_sum;

	modport source (output valid, range_sum, input ready);
	modport sink (input valid, range_sum, output ready);
endinterface

/* sv/shr_ram.sv */
module shr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* sv/shr_add_dec.sv */
module shr_add_dec import shr_pkg::*; (
	input  logic [SIZE_W-1:0] size_bytes,
	output add_dec_t          dec
);

	// largest unit whose count is non-zero wins
	always_comb begin
		dec = '0;
		if (size_bytes[30]) begin
			dec.bump = 1'b1;
			dec.unit = UNIT_GIGA;
			dec.bin  = FIELD_W'(size_bytes[30]);
		end else if (size_bytes[29:20] != '0) begin
			dec.bump = 1'b1;
			dec.unit = UNIT_MEGA;
			dec.bin  = size_bytes[29:20];
		end else if (size_bytes[19:10] != '0) begin
			dec.bump = 1'b1;
			dec.unit = UNIT_KILO;
			dec.bin  = size_bytes[19:10];
		end
	end

endmodule

/* sv/size_histogram_range_sum.sv */
// Reply-size histogram with range-sum queries. The three bin stores (kilobyte,
// megabyte, gigabyte) share one synchronous RAM, addressed by {store, bin}, of
// 3 * 2^clog2(BIN_COUNT) words of BIN_WIDTH bits. After reset the block sweeps
// the RAM to zero, one word a cycle, and takes no request until that is done.
// An add request is a read-modify-write of one bin; a full bin saturates. A
// query request reads its range one bin a cycle through the single read port;
// an empty range or the unused store selector skips the reads and sums to zero.
// The sum saturates at 2^42-1. Requests are handled one at a time. The result
// sits in an output register, so further adds are taken while it waits to be
// collected.
module size_histogram_range_sum import shr_pkg::*; #(
	parameter int BIN_COUNT = 1024,
	parameter int BIN_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	shr_req_if.sink   req,
	shr_rsp_if.source rsp
);

	localparam int IDX_W   = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
	localparam int DEPTH   = 3 << IDX_W;
	localparam int AW      = $clog2(DEPTH);
	localparam int ACC_W   = ((SUM_W > BIN_WIDTH) ? SUM_W : BIN_WIDTH) + 1;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(BIN_COUNT - 1);

	state_t state_q, state_d;

	// RAM ports
	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [BIN_WIDTH-1:0] ram_wdata;
	logic [AW-1:0]        ram_raddr;
	logic [BIN_WIDTH-1:0] ram_rdata;

	// request decode
	add_dec_t   add_dec;
	logic       req_acc;
	logic       add_ok;
	logic       q_empty;
	logic [IDX_W-1:0] q_end;

	// working registers
	logic [AW-1:0]    clr_q;
	logic [AW-1:0]    addr_q;
	logic             bump_q;
	logic [1:0]       unit_q;
	logic [IDX_W-1:0] ptr_q;
	logic [IDX_W-1:0] end_q;
	logic             last_q;
	logic [SUM_W-1:0] acc_q;
	logic [SUM_W-1:0] acc_next;
	logic [ACC_W-1:0] acc_wide;

	// output register
	logic             out_valid_q;
	logic [SUM_W-1:0] out_sum_q;

	shr_add_dec u_add_dec (
		.size_bytes (req.size_bytes),
		.dec        (add_dec)
	);

	shr_ram #(
		.WIDTH (BIN_WIDTH),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign req.ready = (state_q == S_IDLE);
	assign req_acc   = req.valid && req.ready;

	// bins past the store are dropped on add and read as zero on query
	assign add_ok  = add_dec.bump && (32'(add_dec.bin) < 32'(BIN_COUNT));
	assign q_end   = (32'(req.range_high) >= 32'(BIN_COUNT)) ? IDX_LAST
		: IDX_W'(req.range_high);
	assign q_empty = (req.unit_select == UNIT_UNUSED)
		|| (req.range_low > req.range_high)
		|| (32'(req.range_low) >= 32'(BIN_COUNT));

	// running sum, saturating at each step (bins are never negative)
	assign acc_wide = ACC_W'(acc_q) + ACC_W'(ram_rdata);
	assign acc_next = (acc_wide > ACC_W'(SUM_MAX)) ? SUM_MAX : SUM_W'(acc_wide);

	// RAM access
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = (ram_rdata == '1) ? ram_rdata : ram_rdata + BIN_WIDTH'(1);
		if (state_q == S_QUERY) begin
			ram_raddr = {unit_q, ptr_q};
		end else if (req.func == FUNC_ADD) begin
			ram_raddr = {add_dec.unit, IDX_W'(add_dec.bin)};
		end else begin
			ram_raddr = {req.unit_select, IDX_W'(req.range_low)};
		end
		case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			S_ADD: begin
				ram_we = bump_q;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (clr_q == AW'(DEPTH - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_acc) begin
					if (req.func == FUNC_ADD) begin
						state_d = S_ADD;
					end else if (q_empty) begin
						state_d = S_DONE;
					end else begin
						state_d = S_QUERY;
					end
				end
			end
			S_ADD: begin
				state_d = S_IDLE;
			end
			S_QUERY: begin
				if (last_q) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				// wait for the output register to free up
				if (!out_valid_q || rsp.ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (state_q == S_DONE && (!out_valid_q || rsp.ready)) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request context and accumulator
	always_ff @(posedge clk) begin
		if (req_acc) begin
			addr_q <= ram_raddr;
			bump_q <= add_ok;
			unit_q <= req.unit_select;
			ptr_q  <= IDX_W'(req.range_low) + IDX_W'(1);
			end_q  <= q_end;
			last_q <= (IDX_W'(req.range_low) == q_end);
			acc_q  <= '0;
		end else if (state_q == S_QUERY) begin
			acc_q <= acc_next;
			if (!last_q) begin
				ptr_q  <= ptr_q + IDX_W'(1);
				last_q <= (ptr_q == end_q);
			end
		end
		if (state_q == S_DONE && (!out_valid_q || rsp.ready)) begin
			out_sum_q <= acc_q;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.range_sum = out_sum_q;

endmodule

/* verif/shr_checker.sv */
module shr_checker import shr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	shr_req_if   req,
	shr_rsp_if   rsp,
	output int   fails,
	output int   pending
);

	localparam int BINS  = 1024;
	localparam int BIN_W = 32;

	// shadow copy of the three stores, indexed by unit code
	logic [BIN_W-1:0] shadow_bins [3][BINS];
	logic [SUM_W-1:0] sums_due [$];

	function automatic logic [SUM_W-1:0] range_total(logic [1:0] unit,
		logic [FIELD_W-1:0] lo, logic [FIELD_W-1:0] hi);
		longint unsigned acc;
		acc = 0;
		if (unit == UNIT_UNUSED || lo > hi)
			return '0;
		for (int i = int'(lo); i <= int'(hi) && i < BINS; i++)
			acc += 64'(shadow_bins[unit][i]);
		if (acc > 64'(SUM_MAX))
			return SUM_MAX;
		return acc[SUM_W-1:0];
	endfunction

	task automatic tally_size(logic [SIZE_W-1:0] size);
		logic [1:0] unit;
		int         idx;
		if (size >> 30 != 0) begin
			unit = UNIT_GIGA;
			idx  = int'(size >> 30);
		end else if (size >> 20 != 0) begin
			unit = UNIT_MEGA;
			idx  = int'(size >> 20);
		end else if (size >> 10 != 0) begin
			unit = UNIT_KILO;
			idx  = int'(size >> 10);
		end else begin
			return;
		end
		if (idx >= BINS)
			return;
		// saturating increment
		if (shadow_bins[unit][idx] != '1)
			shadow_bins[unit][idx] += BIN_W'(1);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (shadow_bins[u, i])
				shadow_bins[u][i] = '0;
			sums_due.delete();
			fails   = 0;
			pending = 0;
		end else begin
			// result first: a sum is never for a request taken at this same edge
			if (rsp.valid && rsp.ready) begin
				if (sums_due.size() == 0) begin
					$error("range_sum: got %0d with no query outstanding", rsp.range_sum);
					fails++;
				end else begin
					logic [SUM_W-1:0] want;
					want = sums_due.pop_front();
					if (rsp.range_sum !== want) begin
						$error("range_sum: expected %0d, got %0d", want, rsp.range_sum);
						fails++;
					end
				end
			end
			if (req.valid && req.ready) begin
				if (req.func == FUNC_ADD)
					tally_size(req.size_bytes);
				else
					sums_due.push_back(range_total(req.unit_select, req.range_low,
						req.range_high));
			end
			pending = sums_due.size();
		end
	end

endmodule

/* verif/tb_size_histogram_range_sum.sv */
// Stimulus and verdict for the size histogram. Checking lives in shr_checker,
// which watches both channels and hands back a failure count and the number of
// sums still owed.
module tb_size_histogram_range_sum;
	import shr_pkg::*;

	// the block sweeps 3072 words after reset and a full-range query reads
	// 1024 bins, so this leaves plenty of margin
	localparam int IDLE_LIMIT   = 16000;
	localparam int RANDOM_ITEMS = 630;

	logic clk = 1'b0;
	logic arst_n;
	logic steady;	// when set, neither side idles
	int   fails;
	int   pending;
	int   idle_cycles;

	logic [FIELD_W-1:0] hot_bin [4];

	shr_req_if req_ch ();
	shr_rsp_if rsp_ch ();

	size_histogram_range_sum dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	shr_checker chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.fails   (fails),
		.pending (pending)
	);

	always #5 clk = ~clk;

	// Offer one request: optional gap with valid low, then hold it until taken.
	// Called at a falling edge and returns at one, leaving valid high so that a
	// back-to-back request needs no drop.
	task automatic put_request(logic func, logic [SIZE_W-1:0] size, logic [1:0] unit,
		logic [FIELD_W-1:0] lo, logic [FIELD_W-1:0] hi);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			req_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid       = 1'b1;
		req_ch.func        = func;
		req_ch.size_bytes  = size;
		req_ch.unit_select = unit;
		req_ch.range_low   = lo;
		req_ch.range_high  = hi;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
	endtask

	// Hold off until every sum owed has been collected.
	task automatic drain();
		req_ch.valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	// Result side: a fresh stall for every sum taken.
	initial begin
		int stall;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 14);
			if (stall > 0) begin
				rsp_ch.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_ch.ready = 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			@(negedge clk);
		end
	end

	// Watchdog: counts edges at which neither channel moves anything.
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("size_histogram_range_sum: mismatch");
				$finish;
			end
		end
	end

	initial begin
		int                 counted;
		int                 pick;
		logic               func;
		logic [SIZE_W-1:0]  size;
		logic [1:0]         unit;
		logic [FIELD_W-1:0] lo;
		logic [FIELD_W-1:0] hi;
		logic [FIELD_W-1:0] hot;

		arst_n             = 1'b0;
		steady             = 1'b0;
		idle_cycles        = 0;
		req_ch.valid       = 1'b0;
		req_ch.func        = FUNC_ADD;
		req_ch.size_bytes  = '0;
		req_ch.unit_select = UNIT_KILO;
		req_ch.range_low   = '0;
		req_ch.range_high  = '0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		foreach (hot_bin[i])
			hot_bin[i] = FIELD_W'($urandom_range(1, 1023));

		// --- directed part ---
		// the fresh kilobyte store reads back as zero
		put_request(FUNC_QUERY, '0, UNIT_KILO, 10'd0, 10'd1023);
		// sizes under 1 KiB are dropped, then each store's boundaries
		put_request(FUNC_ADD, 31'd0, UNIT_KILO, '0, '0);
		put_request(FUNC_ADD, 31'd1023, UNIT_KILO, '0, '0);
		put_request(FUNC_ADD, 31'd1024, UNIT_KILO, '0, '0);
		put_request(FUNC_ADD, 31'(2**20 - 1), UNIT_KILO, '0, '0);
		put_request(FUNC_ADD, 31'(2**20), UNIT_KILO, '0, '0);
		put_request(FUNC_ADD, 31'(2**30 - 1), UNIT_KILO, '0, '0);
		put_request(FUNC_ADD, 31'(2**30), UNIT_KILO, '0, '0);
		put_request(FUNC_ADD, '1, UNIT_KILO, '0, '0);
		// single bins at both ends, full ranges, each store
		put_request(FUNC_QUERY, '0, UNIT_KILO, 10'd1, 10'd1);
		put_request(FUNC_QUERY, '0, UNIT_KILO, 10'd1023, 10'd1023);
		put_request(FUNC_QUERY, '0, UNIT_KILO, 10'd0, 10'd0);
		put_request(FUNC_QUERY, '0, UNIT_MEGA, 10'd0, 10'd1023);
		put_request(FUNC_QUERY, '0, UNIT_MEGA, 10'd1023, 10'd1023);
		put_request(FUNC_QUERY, '0, UNIT_GIGA, 10'd1, 10'd1);
		put_request(FUNC_QUERY, '0, UNIT_GIGA, 10'd0, 10'd1023);
		// unused selector and empty ranges give zero
		put_request(FUNC_QUERY, '1, UNIT_UNUSED, 10'd0, 10'd1023);
		put_request(FUNC_QUERY, '0, UNIT_KILO, 10'd1023, 10'd0);
		put_request(FUNC_QUERY, '0, UNIT_MEGA, 10'd5, 10'd4);
		// bin saturation and sum overflow need 2^32 adds: out of reach here

		// stop feeding until all sums are back
		drain();

		// --- random part ---
		// adds lean on a few hot bins so that queries see counts above one
		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			if ($urandom_range(0, 29) == 0)
				steady = !steady;
			if ($urandom_range(0, 99) == 0)
				drain();

			hot     = hot_bin[$urandom_range(0, 3)];
			size    = SIZE_W'($urandom_range(0, 32'h7fff_ffff));
			unit    = 2'($urandom_range(0, 3));
			lo      = FIELD_W'($urandom_range(0, 1023));
			hi      = FIELD_W'($urandom_range(0, 1023));
			func    = ($urandom_range(0, 9) < 7) ? FUNC_ADD : FUNC_QUERY;

			if (func == FUNC_ADD) begin
				pick = $urandom_range(0, 19);
				if (pick < 2) begin
					size = SIZE_W'($urandom_range(0, 1023));
				end else if (pick < 9) begin
					if ($urandom_range(0, 1))
						size = {11'd0, hot, 10'($urandom)};
					else
						size = SIZE_W'($urandom_range(1024, 2**20 - 1));
				end else if (pick < 16) begin
					if ($urandom_range(0, 1))
						size = {1'b0, hot, 20'($urandom)};
					else
						size = SIZE_W'($urandom_range(2**20, 2**30 - 1));
				end else begin
					size = SIZE_W'($urandom_range(2**30, 32'h7fff_ffff));
				end
			end else begin
				pick = $urandom_range(0, 9);
				unit = (pick < 4) ? UNIT_KILO : (pick < 8) ? UNIT_MEGA :
					(pick < 9) ? UNIT_GIGA : UNIT_UNUSED;
				pick = $urandom_range(0, 19);
				if (pick < 2) begin
					// empty range
					lo = FIELD_W'($urandom_range(1, 1023));
					hi = FIELD_W'($urandom_range(0, 32'(lo) - 32'd1));
				end else if (pick < 3) begin
					lo = '0;
					hi = '1;
				end else begin
					// mostly narrow windows, so queries stay short
					if (unit == UNIT_GIGA)
						lo = FIELD_W'($urandom_range(0, 3));
					else if ($urandom_range(0, 1))
						lo = hot - FIELD_W'($urandom_range(0,
							(hot < 10'd8) ? 32'(hot) : 32'd8));
					hi = (lo > 10'd999) ? 10'd1023 : lo + FIELD_W'($urandom_range(0, 24));
				end
			end

			put_request(func, size, unit, lo, hi);
			counted++;
		end

		drain();
		// last add may still be writing back; a stray sum would show here
		repeat (40) @(negedge clk);

		if (fails == 0)
			$display("size_histogram_range_sum: match");
		else
			$display("size_histogram_range_sum: mismatch");
		$finish;
	end

endmodule

/* files.f */
sv/shr_pkg.sv
sv/shr_if.sv
sv/shr_ram.sv
sv/shr_add_dec.sv
sv/size_histogram_range_sum.sv
verif/shr_checker.sv
verif/tb_size_histogram_range_sum.sv
